### rtl/core/assert_macros.svh
// Concurrent assertion helpers for the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous reset disable
`define AST_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// Condition that must never be seen at a clock edge
`define AST_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("forbidden condition");

`endif

### rtl/core/xva_pkg.sv
package xva_pkg;

	localparam logic [62:0] MAX63       = '1;
	localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
	localparam logic [45:0] LN2_Q40     = 46'h00B1_7217_F7D2;
	localparam logic [63:0] EXP_LIMIT   = 64'h0000_00B1_7217_F7D2 * 64'd33;
	localparam logic [3:0]  TAYLOR_LAST = 4'd13;

	localparam logic [7:0] CFG_CP_HAZ  = 8'd0;
	localparam logic [7:0] CFG_OWN_HAZ = 8'd1;
	localparam logic [7:0] CFG_REC     = 8'd2;
	localparam logic [7:0] CFG_SPREAD  = 8'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_ERR, OP_MUL_SET, OP_PP, OP_EXP_RANGE, OP_DIV_STEP,
		OP_EXP_INIT, OP_TAY_V, OP_TAY_FIX, OP_EXP_FIN, OP_RND16, OP_RND24,
		OP_RND32, OP_ADD, OP_COMMIT, OP_PUBLISH
	} dp_op_t;

	typedef enum logic [2:0] {
		MS_HAZ_T, MS_TERM_R, MS_RECIP, MS_LOSS_D, MS_TMP_DS, MS_TMP_EXP,
		MS_SPR_STEP, MS_TMP_D
	} mul_sel_t;

	typedef enum logic [1:0] {SUM_CVA, SUM_DVA, SUM_FVA} sum_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_ERR, S_EXP_MUL, S_PP, S_EXP_RANGE, S_EXP_DIV,
		S_EXP_INIT, S_TAY_MUL, S_TAY_V, S_TAY_RCP, S_TAY_FIX, S_EXP_FIN,
		S_CR_LD, S_CR_R1, S_CR_DS, S_CR_R2, S_CR_EX, S_CR_R3, S_CR_ADD,
		S_FV_ST, S_FV_R1, S_FV_D, S_FV_R2, S_FV_E, S_FV_R3, S_FV_ADD,
		S_COMMIT, S_PUBLISH
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t msel;
		sum_sel_t tgt;
		logic     side;
		logic [1:0] pp;
		logic [3:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic order_bad;
		logic exp_big;
		logic out_busy;
	} dp_stat_t;

	// floor(2^35 / k) for the series divisors
	function automatic logic [34:0] recip(input logic [3:0] k);
		logic [34:0] m;
		case (k)
			4'd2:    m = 35'd17179869184;
			4'd3:    m = 35'd11453246122;
			4'd4:    m = 35'd8589934592;
			4'd5:    m = 35'd6871947673;
			4'd6:    m = 35'd5726623061;
			4'd7:    m = 35'd4908534052;
			4'd8:    m = 35'd4294967296;
			4'd9:    m = 35'd3817748707;
			4'd10:   m = 35'd3435973836;
			4'd11:   m = 35'd3123612578;
			4'd12:   m = 35'd2863311530;
			4'd13:   m = 35'd2643056797;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

### rtl/core/xva_ctrl.sv
module xva_ctrl import xva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d, ret_q, ret_d;
	logic       side_q, side_d;
	logic [1:0] pp_q, pp_d;
	logic [3:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			side_q  <= 1'b0;
			pp_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			side_q  <= side_d;
			pp_q    <= pp_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		side_d  = side_q;
		pp_d    = pp_q;
		k_d     = k_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				side_d = 1'b0;
				state_d = stat.order_bad ? S_ERR : S_EXP_MUL;
			end
			S_ERR:       state_d = S_PUBLISH;
			S_EXP_MUL: begin
				pp_d = '0; ret_d = S_EXP_RANGE; state_d = S_PP;
			end
			S_PP: begin
				pp_d = pp_q + 2'd1;
				if (pp_q == 2'd3) state_d = ret_q;
			end
			S_EXP_RANGE: state_d = stat.exp_big ? S_EXP_FIN : S_EXP_DIV;
			S_EXP_DIV:   state_d = S_EXP_INIT;
			S_EXP_INIT: begin
				k_d = 4'd1; state_d = S_TAY_MUL;
			end
			S_TAY_MUL: begin
				pp_d = '0; ret_d = S_TAY_V; state_d = S_PP;
			end
			S_TAY_V: begin
				if (k_q == 4'd1) begin
					k_d = k_q + 4'd1; state_d = S_TAY_MUL;
				end else begin
					state_d = S_TAY_RCP;
				end
			end
			S_TAY_RCP: begin
				pp_d = '0; ret_d = S_TAY_FIX; state_d = S_PP;
			end
			S_TAY_FIX: begin
				if (k_q == TAYLOR_LAST) state_d = S_EXP_FIN;
				else begin
					k_d = k_q + 4'd1; state_d = S_TAY_MUL;
				end
			end
			S_EXP_FIN: begin
				if (!side_q) begin
					side_d = 1'b1; state_d = S_EXP_MUL;
				end else begin
					side_d = 1'b0; state_d = S_CR_LD;
				end
			end
			S_CR_LD: begin
				pp_d = '0; ret_d = S_CR_R1; state_d = S_PP;
			end
			S_CR_R1:     state_d = S_CR_DS;
			S_CR_DS: begin
				pp_d = '0; ret_d = S_CR_R2; state_d = S_PP;
			end
			S_CR_R2:     state_d = S_CR_EX;
			S_CR_EX: begin
				pp_d = '0; ret_d = S_CR_R3; state_d = S_PP;
			end
			S_CR_R3:     state_d = S_CR_ADD;
			S_CR_ADD: begin
				if (!side_q) begin
					side_d = 1'b1; state_d = S_CR_LD;
				end else begin
					side_d = 1'b0; state_d = S_FV_ST;
				end
			end
			S_FV_ST: begin
				pp_d = '0; ret_d = S_FV_R1; state_d = S_PP;
			end
			S_FV_R1:     state_d = S_FV_D;
			S_FV_D: begin
				pp_d = '0; ret_d = S_FV_R2; state_d = S_PP;
			end
			S_FV_R2:     state_d = S_FV_E;
			S_FV_E: begin
				pp_d = '0; ret_d = S_FV_R3; state_d = S_PP;
			end
			S_FV_R3:     state_d = S_FV_ADD;
			S_FV_ADD:    state_d = S_COMMIT;
			S_COMMIT:    state_d = S_PUBLISH;
			S_PUBLISH:   if (!stat.out_busy) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		cmd.msel = MS_HAZ_T;
		cmd.tgt  = SUM_CVA;
		cmd.side = side_q;
		cmd.pp   = pp_q;
		cmd.k    = k_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_ERR:       cmd.op = OP_ERR;
			S_EXP_MUL: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_HAZ_T;
			end
			S_PP:        cmd.op = OP_PP;
			S_EXP_RANGE: cmd.op = OP_EXP_RANGE;
			S_EXP_DIV:   cmd.op = OP_DIV_STEP;
			S_EXP_INIT:  cmd.op = OP_EXP_INIT;
			S_TAY_MUL: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_TERM_R;
			end
			S_TAY_V:     cmd.op = OP_TAY_V;
			S_TAY_RCP: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_RECIP;
			end
			S_TAY_FIX:   cmd.op = OP_TAY_FIX;
			S_EXP_FIN:   cmd.op = OP_EXP_FIN;
			S_CR_LD: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_LOSS_D;
			end
			S_CR_R1:     cmd.op = OP_RND16;
			S_CR_DS: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_TMP_DS;
			end
			S_CR_R2:     cmd.op = OP_RND32;
			S_CR_EX: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_TMP_EXP;
			end
			S_CR_R3:     cmd.op = OP_RND32;
			S_CR_ADD: begin
				cmd.op = OP_ADD; cmd.tgt = side_q ? SUM_DVA : SUM_CVA;
			end
			S_FV_ST: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_SPR_STEP;
			end
			S_FV_R1:     cmd.op = OP_RND24;
			S_FV_D: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_TMP_D;
			end
			S_FV_R2:     cmd.op = OP_RND32;
			S_FV_E: begin
				cmd.op = OP_MUL_SET; cmd.msel = MS_TMP_EXP;
			end
			S_FV_R3:     cmd.op = OP_RND16;
			S_FV_ADD: begin
				cmd.op = OP_ADD; cmd.tgt = SUM_FVA;
			end
			S_COMMIT:    cmd.op = OP_COMMIT;
			S_PUBLISH:   if (!stat.out_busy) cmd.op = OP_PUBLISH;
			default:     cmd.op = OP_NOP;
		endcase
	end

endmodule

### rtl/core/xva_dp.sv
module xva_dp import xva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] point_time,
	input  logic [47:0] positive_exposure,
	input  logic [47:0] negative_exposure,
	input  logic [32:0] discount_factor,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] cva_total,
	output logic [62:0] dva_total,
	output logic [62:0] fva_total,
	output logic [1:0]  status,
	output logic        last_result
);

	// configuration and architectural state
	logic [31:0] chaz_q, ohaz_q;
	logic [16:0] rec_q;
	logic [24:0] spr_q;
	logic [31:0] prev_t_q;
	logic [32:0] surv_c_q, surv_o_q;
	logic [62:0] cva_q, dva_q, fva_q;
	logic        oerr_q;
	logic        out_valid_q;

	// captured item and working registers
	logic [31:0] t_q;
	logic [47:0] epe_q, ene_q;
	logic [32:0] d_q;
	logic        last_q;
	logic [63:0] ma_q, mb_q;
	logic [127:0] acc_q;
	logic [44:0] rem_q;
	logic [5:0]  n_q;
	logic        big_q;
	logic [31:0] r_q, v_q;
	logic [32:0] term_q;
	logic signed [34:0] sum_q;
	logic [32:0] sc_q, so_q;
	logic [62:0] tmp_q;
	logic [62:0] cva_o_q, dva_o_q, fva_o_q;
	logic [1:0]  status_o_q;
	logic        last_o_q;

	logic [16:0] loss;
	logic [24:0] spread;
	logic [32:0] d_clamp;
	logic [32:0] ds;
	logic [31:0] pa, pb;
	logic [63:0] prod;
	logic [127:0] prod_sh;
	logic [63:0] ma_d, mb_d;
	logic [5:0]  n_est;
	logic [45:0] rem_red;
	logic [31:0] q0;
	logic [35:0] q0k, rem_fix;
	logic [32:0] q_fix;
	logic [6:0]  rsh;
	logic [128:0] lo2, shf;
	logic [62:0] rnd;
	logic [62:0] add_a;
	logic [63:0] add_s;
	logic [62:0] add_r;
	logic signed [34:0] sum_pos;
	logic [32:0] exp_res;
	logic [1:0]  st_now;

	assign loss    = 17'd65536 - ((rec_q > 17'd65536) ? 17'd65536 : rec_q);
	assign spread  = (spr_q > 25'd16777216) ? 25'd16777216 : spr_q;
	assign d_clamp = (discount_factor > ONE_Q32) ? ONE_Q32 : discount_factor;

	always_comb begin
		logic [32:0] surv_prev, surv_next;
		surv_prev = cmd.side ? surv_o_q : surv_c_q;
		surv_next = cmd.side ? so_q : sc_q;
		ds        = (surv_prev > surv_next) ? surv_prev - surv_next : '0;
	end

	always_comb begin
		ma_d = '0;
		mb_d = '0;
		case (cmd.msel)
			MS_HAZ_T: begin
				ma_d = 64'(cmd.side ? ohaz_q : chaz_q);
				mb_d = 64'(t_q);
			end
			MS_TERM_R: begin
				ma_d = 64'(term_q); mb_d = 64'(r_q);
			end
			MS_RECIP: begin
				ma_d = 64'(v_q); mb_d = 64'(recip(cmd.k));
			end
			MS_LOSS_D: begin
				ma_d = 64'(loss); mb_d = 64'(d_q);
			end
			MS_TMP_DS: begin
				ma_d = 64'(tmp_q); mb_d = 64'(ds);
			end
			MS_TMP_EXP: begin
				ma_d = 64'(tmp_q); mb_d = 64'(cmd.side ? ene_q : epe_q);
			end
			MS_SPR_STEP: begin
				ma_d = 64'(spread); mb_d = 64'(t_q - prev_t_q);
			end
			MS_TMP_D: begin
				ma_d = 64'(tmp_q); mb_d = 64'(d_q);
			end
			default: begin
				ma_d = '0; mb_d = '0;
			end
		endcase
	end

	// one 32x32 partial product per cycle
	assign pa   = cmd.pp[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb   = cmd.pp[0] ? mb_q[63:32] : mb_q[31:0];
	assign prod = 64'(pa) * 64'(pb);
	always_comb begin
		case (cmd.pp)
			2'd0:    prod_sh = 128'(prod);
			2'd3:    prod_sh = 128'(prod) << 64;
			default: prod_sh = 128'(prod) << 32;
		endcase
	end

	// n = floor(x / ln2); x is below 33*ln2 here, so compare against each multiple
	always_comb begin
		n_est = '0;
		for (int j = 1; j <= 32; j++) begin
			if ({1'b0, rem_q} >= 46'(j) * LN2_Q40) n_est = 6'(j);
		end
	end
	assign rem_red = {1'b0, rem_q} - 46'(n_q) * LN2_Q40;

	// divide by k: reciprocal estimate is exact or one low
	assign q0      = acc_q[66:35];
	assign q0k     = 36'(q0) * 36'(cmd.k);
	assign rem_fix = 36'(v_q) - q0k;
	assign q_fix   = (rem_fix >= 36'(cmd.k)) ? 33'(q0) + 33'd1 : 33'(q0);

	always_comb begin
		case (cmd.op)
			OP_RND16: rsh = 7'd16;
			OP_RND24: rsh = 7'd24;
			default:  rsh = 7'd32;
		endcase
		lo2 = {1'b0, acc_q} + (129'd1 << (rsh - 7'd1));
		shf = lo2 >> rsh;
		rnd = (|shf[128:63]) ? MAX63 : shf[62:0];
	end

	always_comb begin
		case (cmd.tgt)
			SUM_DVA: add_a = dva_q;
			SUM_FVA: add_a = fva_q;
			default: add_a = cva_q;
		endcase
		add_s = 64'(add_a) + 64'(tmp_q);
		add_r = add_s[63] ? MAX63 : add_s[62:0];
	end

	always_comb begin
		sum_pos = sum_q >>> n_q;
		if (big_q || sum_q <= 35'sd0) exp_res = '0;
		else exp_res = sum_pos[32:0];
	end

	always_comb begin
		if (oerr_q) st_now = ST_ORDER;
		else if (cva_q == MAX63 || dva_q == MAX63 || fva_q == MAX63) st_now = ST_SAT;
		else st_now = ST_OK;
	end

	assign stat.order_bad = (t_q <= prev_t_q);
	assign stat.exp_big   = (acc_q[63:0] >= EXP_LIMIT);
	assign stat.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chaz_q <= '0;
			ohaz_q <= '0;
			rec_q  <= '0;
			spr_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CP_HAZ:  chaz_q <= cfg_data;
				CFG_OWN_HAZ: ohaz_q <= cfg_data;
				CFG_REC:     rec_q  <= cfg_data[16:0];
				CFG_SPREAD:  spr_q  <= cfg_data[24:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_t_q    <= '0;
			surv_c_q    <= ONE_Q32;
			surv_o_q    <= ONE_Q32;
			cva_q       <= '0;
			dva_q       <= '0;
			fva_q       <= '0;
			oerr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_PUBLISH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ERR: oerr_q <= 1'b1;
				OP_ADD: begin
					case (cmd.tgt)
						SUM_DVA: dva_q <= add_r;
						SUM_FVA: fva_q <= add_r;
						default: cva_q <= add_r;
					endcase
				end
				OP_COMMIT: begin
					surv_c_q <= sc_q;
					surv_o_q <= so_q;
					prev_t_q <= t_q;
				end
				OP_PUBLISH: begin
					// end of profile: back to the reset values
					if (last_q) begin
						prev_t_q <= '0;
						surv_c_q <= ONE_Q32;
						surv_o_q <= ONE_Q32;
						cva_q    <= '0;
						dva_q    <= '0;
						fva_q    <= '0;
						oerr_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				t_q    <= point_time;
				epe_q  <= positive_exposure;
				ene_q  <= negative_exposure;
				d_q    <= d_clamp;
				last_q <= last_point;
			end
			OP_MUL_SET: begin
				ma_q  <= ma_d;
				mb_q  <= mb_d;
				acc_q <= '0;
			end
			OP_PP: acc_q <= acc_q + prod_sh;
			OP_EXP_RANGE: begin
				big_q <= stat.exp_big;
				rem_q <= acc_q[44:0];
				n_q   <= '0;
			end
			OP_DIV_STEP: n_q <= n_est;
			OP_EXP_INIT: begin
				r_q    <= rem_red[39:8];
				term_q <= ONE_Q32;
				sum_q  <= 35'(ONE_Q32);
			end
			OP_TAY_V: begin
				if (cmd.k == 4'd1) begin
					term_q <= 33'(acc_q[63:32]);
					sum_q  <= sum_q - $signed(35'(acc_q[63:32]));
				end else begin
					v_q <= acc_q[63:32];
				end
			end
			OP_TAY_FIX: begin
				term_q <= q_fix;
				// odd terms subtract
				if (cmd.k[0]) sum_q <= sum_q - $signed(35'(q_fix));
				else sum_q <= sum_q + $signed(35'(q_fix));
			end
			OP_EXP_FIN: begin
				if (cmd.side) so_q <= exp_res;
				else sc_q <= exp_res;
			end
			OP_RND16, OP_RND24, OP_RND32: tmp_q <= rnd;
			OP_PUBLISH: begin
				cva_o_q    <= cva_q;
				dva_o_q    <= dva_q;
				fva_o_q    <= fva_q;
				status_o_q <= st_now;
				last_o_q   <= last_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign cva_total   = cva_o_q;
	assign dva_total   = dva_o_q;
	assign fva_total   = fva_o_q;
	assign status      = status_o_q;
	assign last_result = last_o_q;

endmodule

### rtl/core/xva_exposure_accumulator.sv
// One date in flight: a new date is accepted only after the result of the last one is published.
// A date out of order skips the sums; a side whose exponent is out of range skips the series.
// The shared 32x32 multiplier forms four partial products per product, and the exponential
// series runs through the k = 13 term once per side; a held result stalls the next one.
// Reset (async, active low) clears config to 0, survivals to one, sums and flags to zero.
module xva_exposure_accumulator import xva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] point_time,
	input  logic [47:0] positive_exposure,
	input  logic [47:0] negative_exposure,
	input  logic [32:0] discount_factor,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] cva_total,
	output logic [62:0] dva_total,
	output logic [62:0] fva_total,
	output logic [1:0]  status,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	xva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	xva_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.point_time        (point_time),
		.positive_exposure (positive_exposure),
		.negative_exposure (negative_exposure),
		.discount_factor   (discount_factor),
		.last_point        (last_point),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cva_total         (cva_total),
		.dva_total         (dva_total),
		.fva_total         (fva_total),
		.status            (status),
		.last_result       (last_result)
	);

endmodule

### rtl/core/xva_chk.sv
`include "assert_macros.svh"

module xva_chk import xva_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] point_time,
	input logic [47:0] positive_exposure,
	input logic [47:0] negative_exposure,
	input logic [32:0] discount_factor,
	input logic        last_point,
	input logic        out_valid,
	input logic        out_ready,
	input logic [62:0] cva_total,
	input logic [62:0] dva_total,
	input logic [62:0] fva_total,
	input logic [1:0]  status,
	input logic        last_result,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_index,
	input logic [31:0] cfg_data
);

	`AST_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`AST_CLK(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`AST_CLK(a_sat_status, clk, arst_n, out_valid && status == ST_SAT |-> (cva_total == MAX63 || dva_total == MAX63 || fva_total == MAX63))
	`AST_NEVER(a_status_code, clk, arst_n, out_valid && status == 2'd3)

endmodule

bind xva_exposure_accumulator xva_chk u_xva_chk (.*);
